>>> hdl/bpl_pkg.sv
// Package for the bounded positional list: operation and status codes,
// cell select codes and the controller command struct. No dependencies.
`default_nettype none

package bpl_pkg;

    // Capacity and index widths, fixed by the 5-bit position and length fields
    localparam int LIST_DEPTH = 16;
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 5;
    localparam int STATUS_W   = 2;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_READ   = 3'd4,
        OP_WRITE  = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_RESIZE = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_BAD   = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    // Next-value source of one element cell
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_VALUE = 2'd1,
        CELL_LOWER = 2'd2,
        CELL_UPPER = 2'd3
    } cell_sel_t;

    // Output register occupancy
    typedef enum logic {
        OUT_EMPTY = 1'b0,
        OUT_HELD  = 1'b1
    } out_state_t;

    // Command from controller to datapath
    typedef struct packed {
        logic exec;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> hdl/bpl_cell.sv
// One element cell of the list row: holds, loads the input value, or takes
// its lower or upper neighbor. Depends on bpl_pkg.
`default_nettype none

module bpl_cell
    import bpl_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire cell_sel_t        sel,
    input  wire logic [WIDTH-1:0] value,
    input  wire logic [WIDTH-1:0] lower,
    input  wire logic [WIDTH-1:0] upper,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] elem_reg;
    logic [WIDTH-1:0] elem_next;

    // Pick the next element content
    always_comb begin
        unique case (sel)
            CELL_HOLD:  elem_next = elem_reg;
            CELL_VALUE: elem_next = value;
            CELL_LOWER: elem_next = lower;
            CELL_UPPER: elem_next = upper;
        endcase
    end

    // Element storage, contents undefined until written
    always_ff @(posedge aclk) begin
        elem_reg <= elem_next;
    end

    assign q = elem_reg;

endmodule

`default_nettype wire

>>> hdl/bpl_ctrl.sv
// Handshake controller of the bounded positional list: tracks the output
// register and issues the execute command. Depends on bpl_pkg.
`default_nettype none

module bpl_ctrl
    import bpl_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output ctrl_cmd_t cmd
);

    out_state_t state_reg;
    out_state_t state_next;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    // Next state
    always_comb begin
        unique case (state_reg)
            OUT_EMPTY: state_next = accept ? OUT_HELD : OUT_EMPTY;
            OUT_HELD:  state_next = (m_tready && !accept) ? OUT_EMPTY : OUT_HELD;
        endcase
    end

    // Outputs: accept a word when the output register is empty or its held result leaves in this cycle
    always_comb begin
        unique case (state_reg)
            OUT_EMPTY: begin
                s_tready = 1'b1;
                m_tvalid = 1'b0;
            end
            OUT_HELD: begin
                s_tready = m_tready;
                m_tvalid = 1'b1;
            end
        endcase
        cmd.exec = accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= OUT_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/bpl_datapath.sv
// Datapath of the bounded positional list: operation decode, length
// register, row of element cells and result register. Depends on bpl_pkg, bpl_cell.
`default_nettype none

module bpl_datapath
    import bpl_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ctrl_cmd_t           cmd,
    input  wire op_t                 op,
    input  wire logic [POS_W-1:0]    position,
    input  wire logic [VALUE_W-1:0]  value,
    input  wire logic [LEN_W-1:0]    new_length,
    output logic      [VALUE_W-1:0]  read_value,
    output logic      [LEN_W-1:0]    length,
    output status_t                  status
);

    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(LIST_DEPTH);
    localparam logic [LEN_W-1:0] ONE_L   = LEN_W'(1);

    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;
    status_t                  st;
    logic                     ok;
    logic [VALUE_W-1:0]       rd;
    logic [ELEMENT_WIDTH-1:0] elem_value;
    logic [ELEMENT_WIDTH-1:0] elem_q [LIST_DEPTH];
    logic [VALUE_W-1:0]       read_value_reg;
    logic [LEN_W-1:0]         length_reg;
    status_t                  status_reg;

    assign elem_value = ELEMENT_WIDTH'(value);

    // Decode status and the new length
    always_comb begin
        st       = STATUS_OK;
        len_next = len_reg;
        unique case (op)
            OP_PUSH: begin
                if (len_reg >= DEPTH_L) st = STATUS_FULL;
                else                    len_next = len_reg + ONE_L;
            end
            OP_POP: begin
                if (len_reg == '0) st = STATUS_EMPTY;
                else               len_next = len_reg - ONE_L;
            end
            OP_INSERT: begin
                if (position > len_reg)       st = STATUS_BAD;
                else if (len_reg >= DEPTH_L)  st = STATUS_FULL;
                else                          len_next = len_reg + ONE_L;
            end
            OP_ERASE: begin
                if (position >= len_reg) st = STATUS_BAD;
                else                     len_next = len_reg - ONE_L;
            end
            OP_READ, OP_WRITE: begin
                if (position >= len_reg) st = STATUS_BAD;
            end
            OP_CLEAR: begin
                len_next = '0;
            end
            OP_RESIZE: begin
                if (new_length > DEPTH_L) st = STATUS_BAD;
                else                      len_next = new_length;
            end
        endcase
        ok = (st == STATUS_OK);
    end

    // Read the addressed element, zero for anything but a good read
    always_comb begin
        rd = '0;
        if (op == OP_READ && ok) begin
            rd = VALUE_W'(elem_q[position[IDX_W-1:0]]);
        end
    end

    // Row of cells, each deciding its own source from the decoded operation
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        localparam logic [LEN_W-1:0] IDX  = LEN_W'(i);
        localparam logic [LEN_W-1:0] IDX1 = LEN_W'(i + 1);
        cell_sel_t                sel;
        logic [ELEMENT_WIDTH-1:0] lower;
        logic [ELEMENT_WIDTH-1:0] upper;

        if (i == 0) begin : g_first
            assign lower = '0;
        end else begin : g_mid_lo
            assign lower = elem_q[i-1];
        end
        if (i == LIST_DEPTH - 1) begin : g_last
            assign upper = '0;
        end else begin : g_mid_hi
            assign upper = elem_q[i+1];
        end

        always_comb begin
            sel = CELL_HOLD;
            if (cmd.exec && ok) begin
                unique case (op)
                    OP_PUSH: begin
                        if (IDX == len_reg) sel = CELL_VALUE;
                    end
                    OP_INSERT: begin
                        if (IDX == position)
                            sel = CELL_VALUE;
                        else if (IDX > position && IDX <= len_reg)
                            sel = CELL_LOWER;
                    end
                    OP_ERASE: begin
                        if (IDX >= position && IDX1 < len_reg) sel = CELL_UPPER;
                    end
                    OP_WRITE: begin
                        if (IDX == position) sel = CELL_VALUE;
                    end
                    OP_RESIZE: begin
                        if (IDX >= len_reg && IDX < new_length) sel = CELL_VALUE;
                    end
                    OP_POP, OP_READ, OP_CLEAR: begin
                        sel = CELL_HOLD;
                    end
                endcase
            end
        end

        bpl_cell #(
            .WIDTH(ELEMENT_WIDTH)
        ) u_cell (
            .aclk (aclk),
            .sel  (sel),
            .value(elem_value),
            .lower(lower),
            .upper(upper),
            .q    (elem_q[i])
        );
    end

    // Length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cmd.exec) begin
            len_reg <= len_next;
        end
    end

    // Result register, loaded with each accepted word
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            read_value_reg <= rd;
            length_reg     <= len_next;
            status_reg     <= st;
        end
    end

    assign read_value = read_value_reg;
    assign length     = length_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

>>> hdl/bounded_positional_list.sv
// Bounded positional list, top level: stream ports, controller and datapath.
// A result word appears on the master side in the cycle after its input word.
// One word per cycle while m_tready is high; all cells update in the accepting cycle.
// Reset (aresetn low, synchronous) empties the list and the output register;
// element contents are not cleared. Depends on bpl_pkg, bpl_ctrl, bpl_datapath.
`default_nettype none

module bounded_positional_list
    import bpl_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: op[2:0], position[7:3], value[39:8], new_length[44:40], zero[47:45]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    // m_tdata: read_value[31:0], length[36:32], status[38:37], zero[39]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata
);

    ctrl_cmd_t            cmd;
    logic [VALUE_W-1:0]   read_value;
    logic [LEN_W-1:0]     length;
    status_t              status;

    bpl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd)
    );

    bpl_datapath #(
        .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .op        (op_t'(s_tdata[2:0])),
        .position  (s_tdata[7:3]),
        .value     (s_tdata[39:8]),
        .new_length(s_tdata[44:40]),
        .read_value(read_value),
        .length    (length),
        .status    (status)
    );

    // Pack the result word
    assign m_tdata = {1'b0, status, length, read_value};

endmodule

`default_nettype wire
